[rtl/sus_pkg.sv]
// shared types and constants for the sorted unique set
package sus_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

endpackage

[rtl/sus_cell.sv]
// one storage cell of the sorted chain
module sus_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sus_pkg::cmd_t                    cmd,
	input  logic signed [sus_pkg::KEY_W-1:0] key,
	input  logic signed [sus_pkg::KEY_W-1:0] left_value,
	input  logic                             left_valid,
	input  logic                             left_less,
	input  logic signed [sus_pkg::KEY_W-1:0] right_value,
	input  logic                             right_valid,
	output logic signed [sus_pkg::KEY_W-1:0] value_out,
	output logic                             valid_out,
	output logic                             less,
	output logic                             eq
);

	logic signed [sus_pkg::KEY_W-1:0] value_q;
	logic                             valid_q;

	assign less      = valid_q && (value_q < key);
	assign eq        = valid_q && (value_q == key);
	assign value_out = value_q;
	assign valid_out = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !less) begin
			valid_q <= left_valid;
		end else if (cmd.rem && !less) begin
			valid_q <= right_valid;
		end
	end

	// cells at or above the sorted position move up on insert, down on remove
	always_ff @(posedge clk) begin
		if (cmd.ins && !less) begin
			value_q <= left_less ? cmd.key : left_value;
		end else if (cmd.rem && !less) begin
			value_q <= right_value;
		end
	end

endmodule

[rtl/sorted_unique_set_unit.sv]
// top level: sorted set of distinct signed keys held in a chain of cells
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------
//  in      | in_valid  | in_ready  | action, value
//  out     | out_valid | out_ready | success, entry_count
//
// all cells compare the key in parallel and shift toward their neighbor in
// the same edge, so a transfer can occur each cycle while in_ready is high;
// the cell compare plus the hit reduction sets the clock path
// the result is registered in the cycle after the input transfer
// in_ready stays high while the output register is empty or being drained
// reset empties the store at once; no clearing pass is needed
module sorted_unique_set_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic signed [sus_pkg::KEY_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             success,
	output logic [4:0]                       entry_count
);

	localparam int N = sus_pkg::CAPACITY;

	logic signed [sus_pkg::KEY_W-1:0] cell_value [N];
	logic [N-1:0]                     cell_valid;
	logic [N-1:0]                     cell_less;
	logic [N-1:0]                     cell_eq;

	logic [sus_pkg::CNT_W-1:0] count_q;
	logic                      out_valid_q;
	logic                      success_q;

	logic          accept;
	logic          hit;
	logic          full;
	logic          ok;
	sus_pkg::cmd_t cmd;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign hit      = |cell_eq;
	assign full     = (count_q == sus_pkg::CNT_W'(N));

	always_comb begin
		ok = 1'b0;
		unique case (action)
			sus_pkg::ACT_INSERT: ok = !hit && !full;
			sus_pkg::ACT_REMOVE: ok = hit;
			sus_pkg::ACT_LOOKUP: ok = hit;
			default:             ok = 1'b0;
		endcase
	end

	always_comb begin
		cmd.key = value;
		cmd.ins = accept && (action == sus_pkg::ACT_INSERT) && ok;
		cmd.rem = accept && (action == sus_pkg::ACT_REMOVE) && ok;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [sus_pkg::KEY_W-1:0] lv;
		logic                             lval;
		logic                             lless;
		logic signed [sus_pkg::KEY_W-1:0] rv;
		logic                             rval;

		// the head cell sees a virtual smaller, valid neighbor on its left
		if (i == 0) begin : g_head
			assign lv    = value;
			assign lval  = 1'b1;
			assign lless = 1'b1;
		end else begin : g_mid
			assign lv    = cell_value[i-1];
			assign lval  = cell_valid[i-1];
			assign lless = cell_less[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign rv   = value;
			assign rval = 1'b0;
		end else begin : g_body
			assign rv   = cell_value[i+1];
			assign rval = cell_valid[i+1];
		end

		sus_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.key         (value),
			.left_value  (lv),
			.left_valid  (lval),
			.left_less   (lless),
			.right_value (rv),
			.right_valid (rval),
			.value_out   (cell_value[i]),
			.valid_out   (cell_valid[i]),
			.less        (cell_less[i]),
			.eq          (cell_eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + sus_pkg::CNT_W'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - sus_pkg::CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			success_q <= ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign entry_count = 5'(count_q);

`ifndef SYNTHESIS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("stored count differs from number of valid cells");

	a_keys_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_eq))
		else $error("key matched in more than one cell");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("valid cells do not form a prefix");

	a_insert_reports_success: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> out_valid_q && success_q)
		else $error("insert did not report success");
`endif

endmodule
